// ----- rtl/bcn_pkg.sv -----
// Shared types, constants and endpoint helpers for the BC1..BC5 texel decoder.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package bcn_pkg;

    // Block format codes held in the configuration register
    typedef enum logic [2:0] {
        FMT_BC1   = 3'd0,
        FMT_BC2   = 3'd1,
        FMT_BC3   = 3'd2,
        FMT_BC4U  = 3'd3,
        FMT_BC4S  = 3'd4,
        FMT_BC5U  = 3'd5,
        FMT_BC5S  = 3'd6
    } t_fmt;

    // Color channel operation chosen in the first arithmetic stage
    typedef enum logic [1:0] {
        CM_PASS,
        CM_DIV3,
        CM_HALF,
        CM_ZERO
    } t_cmode;

    // Single-channel ramp operation chosen in the first arithmetic stage
    typedef enum logic [2:0] {
        RM_PASS,
        RM_DIV7,
        RM_DIV5,
        RM_LO,
        RM_HI
    } t_rmode;

    // Reciprocals: floor(n*K >> S) equals floor(n/d) over the numerator ranges used
    localparam logic [9:0]  RECIP3       = 10'd683;
    localparam int          RECIP3_SHIFT = 11;
    localparam logic [11:0] RECIP7       = 12'd2341;
    localparam logic [11:0] RECIP5       = 12'd3277;
    localparam int          RECIP_SHIFT  = 14;

    localparam logic [7:0]  BYTE_MAX     = 8'hFF;
    localparam logic [7:0]  SIGN_FLIP    = 8'h80;

    typedef struct packed {
        logic [15:0] c0;
        logic [15:0] c1;
        logic [1:0]  sel;
        logic        four;
    } t_color_in;

    typedef struct packed {
        logic [7:0] u0;
        logic [7:0] u1;
        logic [2:0] code;
        logic       sgn;
    } t_ramp_in;

    // Per-texel data that rides alongside the arithmetic units
    typedef struct packed {
        t_fmt       fmt;
        logic [3:0] idx;
        logic       last;
        logic [3:0] nib;
    } t_side;

    typedef struct packed {
        t_side      side;
        t_color_in  color;
        t_ramp_in   ramp0;
        t_ramp_in   ramp1;
    } t_s1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] idx;
        logic       last;
    } t_texel;

    // 565 endpoint widening by top-bit replication
    function automatic logic [7:0] wide_r(input logic [15:0] c);
        return {c[15:11], c[15:13]};
    endfunction

    function automatic logic [7:0] wide_g(input logic [15:0] c);
        return {c[10:5], c[10:9]};
    endfunction

    function automatic logic [7:0] wide_b(input logic [15:0] c);
        return {c[4:0], c[4:2]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bcn_fetch.sv -----
// Block holding register, texel counter and per-texel field extraction (stage 1).
// Depends on bcn_pkg.
`default_nettype none

module bcn_fetch
    import bcn_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire t_fmt        i_fmt,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_blk_lo,
    input  wire logic [63:0] i_blk_hi,
    output logic             o_s1_valid,
    output t_s1              o_s1
);

    logic [63:0] r_blk_lo;
    logic [63:0] r_blk_hi;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_s1_valid;
    t_s1         r_s1;
    t_s1         n_s1;

    logic        w_issue;
    logic        w_take;
    logic [63:0] w_cword;
    logic [5:0]  w_sel_pos;
    logic [5:0]  w_code_pos;
    logic [5:0]  w_nib_pos;

    assign w_issue    = r_busy && i_en;
    assign o_in_ready = !r_busy || (w_issue && (r_cnt == 4'hF));
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        w_cword    = (i_fmt == FMT_BC1) ? r_blk_lo : r_blk_hi;
        w_sel_pos  = 6'd32 + {1'b0, r_cnt, 1'b0};
        w_code_pos = 6'd16 + {1'b0, r_cnt, 1'b0} + {2'b00, r_cnt};
        w_nib_pos  = {r_cnt, 2'b00};

        n_s1.side.fmt  = i_fmt;
        n_s1.side.idx  = r_cnt;
        n_s1.side.last = (r_cnt == 4'hF);
        n_s1.side.nib  = r_blk_lo[w_nib_pos +: 4];

        n_s1.color.c0   = w_cword[15:0];
        n_s1.color.c1   = w_cword[31:16];
        n_s1.color.sel  = w_cword[w_sel_pos +: 2];
        // Only BC1 drops to three-color mode on ordered endpoints
        n_s1.color.four = (i_fmt != FMT_BC1) || (w_cword[15:0] > w_cword[31:16]);

        n_s1.ramp0.u0   = r_blk_lo[7:0];
        n_s1.ramp0.u1   = r_blk_lo[15:8];
        n_s1.ramp0.code = r_blk_lo[w_code_pos +: 3];
        n_s1.ramp0.sgn  = (i_fmt == FMT_BC4S) || (i_fmt == FMT_BC5S);

        n_s1.ramp1.u0   = r_blk_hi[7:0];
        n_s1.ramp1.u1   = r_blk_hi[15:8];
        n_s1.ramp1.code = r_blk_hi[w_code_pos +: 3];
        n_s1.ramp1.sgn  = (i_fmt == FMT_BC5S);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_cnt      <= 4'h0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_s1_valid <= r_busy;
            end
            if (w_take) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'h0;
            end else if (w_issue) begin
                r_cnt <= r_cnt + 4'h1;
                if (r_cnt == 4'hF) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_blk_lo <= i_blk_lo;
            r_blk_hi <= i_blk_hi;
        end
        if (w_issue) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

`default_nettype wire

// ----- rtl/bcn_color.sv -----
// Two-stage RGB endpoint interpolation for the 565 color half of BC1/BC2/BC3.
// Depends on bcn_pkg.
`default_nettype none

module bcn_color
    import bcn_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  wire t_color_in i_color,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue,
    output logic           o_clear
);

    logic [7:0]  w_e0 [3];
    logic [7:0]  w_e1 [3];
    logic [9:0]  n_num [3];
    t_cmode      n_mode;
    logic        n_clear;

    logic [9:0]  r_num [3];
    t_cmode      r_mode;
    logic        r_clear;

    logic [19:0] w_prod [3];
    logic [7:0]  n_val [3];
    logic [7:0]  r_val [3];
    logic        r_clear2;

    always_comb begin
        w_e0[0] = wide_r(i_color.c0);
        w_e0[1] = wide_g(i_color.c0);
        w_e0[2] = wide_b(i_color.c0);
        w_e1[0] = wide_r(i_color.c1);
        w_e1[1] = wide_g(i_color.c1);
        w_e1[2] = wide_b(i_color.c1);
        n_clear = 1'b0;
        case (i_color.sel)
            2'd0:    n_mode = CM_PASS;
            2'd1:    n_mode = CM_PASS;
            2'd2:    n_mode = i_color.four ? CM_DIV3 : CM_HALF;
            default: begin
                n_mode  = i_color.four ? CM_DIV3 : CM_ZERO;
                n_clear = !i_color.four;
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            case (i_color.sel)
                2'd0:    n_num[k] = {2'b00, w_e0[k]};
                2'd1:    n_num[k] = {2'b00, w_e1[k]};
                2'd2:    n_num[k] = i_color.four
                                  ? {1'b0, w_e0[k], 1'b0} + {2'b00, w_e1[k]}
                                  : {2'b00, w_e0[k]} + {2'b00, w_e1[k]};
                default: n_num[k] = {2'b00, w_e0[k]} + {1'b0, w_e1[k], 1'b0};
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_prod[k] = r_num[k] * RECIP3;
            case (r_mode)
                CM_PASS: n_val[k] = r_num[k][7:0];
                CM_DIV3: n_val[k] = 8'(w_prod[k] >> RECIP3_SHIFT);
                CM_HALF: n_val[k] = r_num[k][8:1];
                default: n_val[k] = 8'h00;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num    <= n_num;
            r_mode   <= n_mode;
            r_clear  <= n_clear;
            r_val    <= n_val;
            r_clear2 <= r_clear;
        end
    end

    assign o_red   = r_val[0];
    assign o_green = r_val[1];
    assign o_blue  = r_val[2];
    assign o_clear = r_clear2;

endmodule

`default_nettype wire

// ----- rtl/bcn_ramp.sv -----
// Two-stage single-channel 3-bit ramp decode (BC3 alpha, BC4, BC5 channels).
// Depends on bcn_pkg.
`default_nettype none

module bcn_ramp
    import bcn_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  wire t_ramp_in i_ramp,
    output logic [7:0]    o_value
);

    logic signed [12:0] w_a0;
    logic signed [12:0] w_a1;
    logic signed [12:0] w_w0;
    logic signed [12:0] w_w1;
    logic signed [12:0] w_num;
    logic               w_gt;
    logic [3:0]         w_wt0;
    logic [3:0]         w_wt1;

    t_rmode             n_mode;
    logic [10:0]        n_mag;
    logic               n_neg;
    t_rmode             r_mode;
    logic [10:0]        r_mag;
    logic               r_neg;
    logic               r_sgn;

    logic [22:0]        w_prod;
    logic [7:0]         w_q;
    logic [7:0]         w_v;
    logic [7:0]         n_value;
    logic [7:0]         r_value;

    always_comb begin
        // Endpoints as 13-bit two's complement, sign-extended for signed formats
        w_a0 = i_ramp.sgn ? 13'(signed'(i_ramp.u0)) : {5'b0, i_ramp.u0};
        w_a1 = i_ramp.sgn ? 13'(signed'(i_ramp.u1)) : {5'b0, i_ramp.u1};
        w_gt = w_a0 > w_a1;
        w_wt0 = w_gt ? (4'd8 - {1'b0, i_ramp.code}) : (4'd6 - {1'b0, i_ramp.code});
        w_wt1 = {1'b0, i_ramp.code} - 4'd1;
        w_w0  = {9'b0, w_wt0};
        w_w1  = {9'b0, w_wt1};
        w_num = w_a0 * w_w0 + w_a1 * w_w1;
        n_neg = 1'b0;
        n_mag = 11'(unsigned'(w_num[12] ? -w_num : w_num));
        if (i_ramp.code == 3'd0) begin
            n_mode = RM_PASS;
            n_mag  = {3'b000, i_ramp.u0};
        end else if (i_ramp.code == 3'd1) begin
            n_mode = RM_PASS;
            n_mag  = {3'b000, i_ramp.u1};
        end else if (w_gt) begin
            n_mode = RM_DIV7;
            n_neg  = w_num[12];
        end else if (i_ramp.code < 3'd6) begin
            n_mode = RM_DIV5;
            n_neg  = w_num[12];
        end else if (i_ramp.code == 3'd6) begin
            n_mode = RM_LO;
        end else begin
            n_mode = RM_HI;
        end
    end

    always_comb begin
        w_prod = r_mag * ((r_mode == RM_DIV7) ? RECIP7 : RECIP5);
        w_q    = (r_mode == RM_PASS) ? r_mag[7:0] : 8'(w_prod >> RECIP_SHIFT);
        // Truncate toward zero: divide the magnitude, then restore the sign
        w_v    = r_neg ? (8'h00 - w_q) : w_q;
        case (r_mode)
            RM_PASS: n_value = w_v ^ (r_sgn ? SIGN_FLIP : 8'h00);
            RM_DIV7: n_value = w_v ^ (r_sgn ? SIGN_FLIP : 8'h00);
            RM_DIV5: n_value = w_v ^ (r_sgn ? SIGN_FLIP : 8'h00);
            RM_LO:   n_value = 8'h00;
            default: n_value = BYTE_MAX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode  <= n_mode;
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_sgn   <= i_ramp.sgn;
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- rtl/bcn_block_texel_decoder.sv -----
// Top level of the BC1..BC5 texel decoder: format register, pipeline control,
// channel assembly and output register. Depends on bcn_pkg, bcn_fetch, bcn_color, bcn_ramp.
//
// Usage:
//   Slave stream (i_s_axis_*): one transaction carries one 16-byte compressed block,
//   bytes 0..7 in tdata[63:0] and bytes 8..15 in tdata[127:64], little endian.
//   Master stream (o_m_axis_*): sixteen transactions per block, one texel each, in
//   row order; tlast marks texel 15.
//   Config channel (i_cfg_*): writes the 3-bit block format. Write it only while no
//   block is in flight; o_cfg_ready is always high.
// Latency and throughput:
//   The first texel of a block passes the block holder, the stage-1 register, the two
//   arithmetic stages and the output register before it reaches the master side. One
//   texel leaves per cycle while the receiver accepts; the fetch-stage texel counter
//   steps through the sixteen texels. The next block is taken in the same cycle the last
//   texel of the current one is issued, so blocks stream back to back with no gap.
// Reset (synchronous, active low) clears the format to BC1, drops every valid bit
// and empties the block holder. When the receiver stalls, the whole pipeline
// holds in place; nothing is dropped or repeated.
`default_nettype none

module bcn_block_texel_decoder
    import bcn_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_data,      // block_format

    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,  // [63:0] block_low, [127:64] block_high

    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [39:0]       o_m_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue,
                                               // [31:24] alpha, [35:32] texel_index, rest 0
    output logic              o_m_axis_tlast   // last_texel
);

    t_fmt       r_fmt;
    logic       w_en;

    logic       w_s1_valid;
    t_s1        w_s1;

    logic       r_s2_valid;
    t_side      r_s2_side;
    logic       r_s3_valid;
    t_side      r_s3_side;

    logic [7:0] w_red;
    logic [7:0] w_green;
    logic [7:0] w_blue;
    logic       w_clear;
    logic [7:0] w_ramp0;
    logic [7:0] w_ramp1;

    t_texel     n_out;
    t_texel     r_out;
    logic       r_out_valid;

    // Advance every stage unless a finished texel is stuck at the output
    assign w_en = !r_out_valid || i_m_axis_tready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_BC1;
        end else if (i_cfg_valid) begin
            r_fmt <= t_fmt'(i_cfg_data);
        end
    end

    bcn_fetch u_fetch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_fmt      (r_fmt),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_blk_lo   (i_s_axis_tdata[63:0]),
        .i_blk_hi   (i_s_axis_tdata[127:64]),
        .o_s1_valid (w_s1_valid),
        .o_s1       (w_s1)
    );

    bcn_color u_color (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_color (w_s1.color),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue),
        .o_clear (w_clear)
    );

    // Channel from block bytes 0..7: BC3 alpha, BC4 grey, BC5 red
    bcn_ramp u_ramp0 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_ramp  (w_s1.ramp0),
        .o_value (w_ramp0)
    );

    // Channel from block bytes 8..15: BC5 green
    bcn_ramp u_ramp1 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_ramp  (w_s1.ramp1),
        .o_value (w_ramp1)
    );

    // Assemble the texel from the unit results according to the carried format
    always_comb begin
        n_out.idx   = r_s3_side.idx;
        n_out.last  = r_s3_side.last;
        n_out.red   = 8'h00;
        n_out.green = 8'h00;
        n_out.blue  = 8'h00;
        n_out.alpha = 8'h00;
        case (r_s3_side.fmt)
            FMT_BC1: begin
                n_out.red   = w_red;
                n_out.green = w_green;
                n_out.blue  = w_blue;
                n_out.alpha = w_clear ? 8'h00 : BYTE_MAX;
            end
            FMT_BC2: begin
                n_out.red   = w_red;
                n_out.green = w_green;
                n_out.blue  = w_blue;
                n_out.alpha = {r_s3_side.nib, r_s3_side.nib};
            end
            FMT_BC3: begin
                n_out.red   = w_red;
                n_out.green = w_green;
                n_out.blue  = w_blue;
                n_out.alpha = w_ramp0;
            end
            FMT_BC4U, FMT_BC4S: begin
                n_out.red   = w_ramp0;
                n_out.green = w_ramp0;
                n_out.blue  = w_ramp0;
                n_out.alpha = BYTE_MAX;
            end
            FMT_BC5U, FMT_BC5S: begin
                n_out.red   = w_ramp0;
                n_out.green = w_ramp1;
                n_out.alpha = BYTE_MAX;
            end
            default: begin
                // Unused format code: emit black with zero alpha
                n_out.alpha = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid  <= w_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_side <= w_s1.side;
            r_s3_side <= r_s2_side;
            r_out     <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'h0, r_out.idx, r_out.alpha, r_out.blue, r_out.green, r_out.red};
    assign o_m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire
